FILE: src/vpcc_pkg.sv
// Shared constants, types and the log2 fraction table for the pitch correction control.
// No dependencies; imported by every module of the block.
package vpcc_pkg;

	localparam int MAX_FRAME_SAMPLES  = 1024;
	localparam int LOG2_TABLE_ENTRIES = 256;
	localparam int LG_BITS            = $clog2(LOG2_TABLE_ENTRIES);
	localparam int FS_W               = $clog2(MAX_FRAME_SAMPLES + 1);

	// Q16 constants
	localparam int Q16_ONE        = 65536;
	localparam int LOG2_440P4_Q16 = 837639;
	localparam int MIDI_A4_Q16    = 69 * Q16_ONE;
	localparam int OCTAVE_Q16     = 12 * Q16_ONE;
	localparam int HALF_OCT_Q16   = 6 * Q16_ONE;

	// shared multiplier operand and product widths
	localparam int MUL_A_W = 28;
	localparam int MUL_B_W = 21;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;
	localparam int MIDI_W  = 25;
	localparam int LG_W    = 17;

	typedef struct packed {
		logic signed [MUL_A_W-1:0] a;
		logic signed [MUL_B_W-1:0] b;
	} mul_req_t;

	typedef logic [LG_W-1:0] lg_tab_t [LOG2_TABLE_ENTRIES+1];

	// log2 of a Q30 mantissa in [1,2) as a Q16 fraction, by repeated squaring
	function automatic logic [15:0] frac_log2(input logic [63:0] m_in);
		logic [63:0] m;
		logic [15:0] f;
		m = m_in;
		f = '0;
		for (int b = 15; b >= 0; b--) begin
			m = (m * m) >> 30;
			if (m >= 64'h0000_0000_8000_0000) begin
				f[b] = 1'b1;
				m = m >> 1;
			end
		end
		return f;
	endfunction

	function automatic lg_tab_t build_lg_table();
		lg_tab_t t;
		logic [63:0] m;
		for (int i = 0; i < LOG2_TABLE_ENTRIES; i++) begin
			m = (64'd1 << 30) + ((64'(i) << 30) / LOG2_TABLE_ENTRIES);
			t[i] = LG_W'(frac_log2(m));
		end
		t[LOG2_TABLE_ENTRIES] = LG_W'(Q16_ONE);
		return t;
	endfunction

	localparam lg_tab_t LG_TABLE = build_lg_table();

endpackage

FILE: src/vocal_pitch_correction_control.sv
// Vocal pitch correction control, top level: stream ports, config registers,
// sequencer and the datapath around the shared multiplier. Uses vpcc_pkg,
// vpcc_mul and vpcc_midi_conv.
// The decay path skips the error, weight and correction steps; correcting against
// the target adds a second conversion, of the target pitch, after the sung note.
// One item is in flight at a time, as the single shared multiplier is used in turn.
// Reset: arst_n clears the state to zero and the registers to full strength,
// no manual shift, melody off; no result pending.
module vocal_pitch_correction_control import vpcc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// config write port
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [14:0] cfg_data,
	// input items
	input  logic        s_tvalid,
	output logic        s_tready,
	// [15:0] mic_pitch, [26:16] mic_confidence, [42:27] target_pitch,
	// [52:43] zero_crossings, [63:53] frame_samples
	input  logic [63:0] s_tdata,
	// [0] audio_present
	input  logic        s_tuser,
	// result items
	output logic        m_tvalid,
	input  logic        m_tready,
	// [14:0] correction_semitones, [30:15] applied_semitones, [31] corrected,
	// [32] consonant, [33] mic_voiced, [40:34] mic_midi_note, rest zero
	output logic [47:0] m_tdata
);

	localparam logic [1:0] REG_STRENGTH = 2'd0;
	localparam logic [1:0] REG_SHIFT    = 2'd1;
	localparam logic [1:0] REG_MELODY   = 2'd2;

	// result bit positions
	localparam int B_CORR  = 31;
	localparam int B_CONS  = 32;
	localparam int B_VOICE = 33;

	typedef enum logic [3:0] {
		ST_IDLE, ST_MIC_LG, ST_MIC_FIN, ST_TGT_LG, ST_TGT_FIN, ST_ERR, ST_WS,
		ST_EWS, ST_CORR, ST_SM1, ST_SM2, ST_DEC1, ST_DEC2, ST_DONE
	} state_t;

	state_t state_q;

	// config registers
	logic [10:0]        strength_q;
	logic signed [14:0] shift_q;
	logic               melody_q;

	// item context
	logic [15:0] mic_q;
	logic [15:0] tgt_q;
	logic        cons_q;
	logic        run_q;
	logic        use_tgt_q;
	logic        voiced_q;
	logic        corrected_q;
	logic [6:0]  note_q;

	// datapath
	logic signed [14:0]       s_q;
	logic signed [MIDI_W-1:0] user_q;
	logic signed [8:0]        tnote_q;
	logic signed [19:0]       err_q;
	logic [15:0]              w_q;
	logic signed [14:0]       corr_q;
	logic signed [31:0]       acc_q;
	logic                     m_tvalid_q;
	logic [47:0]              m_tdata_q;

	// input fields
	logic [15:0]   in_mic;
	logic [10:0]   in_conf;
	logic [15:0]   in_tgt;
	logic [9:0]    in_zc;
	logic [10:0]   in_fs;
	logic [FS_W-1:0] fs_c;
	logic          in_cons;

	assign in_mic  = s_tdata[15:0];
	assign in_conf = s_tdata[26:16];
	assign in_tgt  = s_tdata[42:27];
	assign in_zc   = s_tdata[52:43];
	assign in_fs   = s_tdata[63:53];

	// consonant: audio present, zero-crossing rate above 0.35, frame of two or more samples
	always_comb begin
		fs_c = (in_fs > 11'(MAX_FRAME_SAMPLES)) ? FS_W'(MAX_FRAME_SAMPLES) : FS_W'(in_fs);
		in_cons = s_tuser && (fs_c > FS_W'(1)) &&
			((17'(in_zc) * 17'd20) > (17'(fs_c) * 17'd7));
	end

	// shared units
	mul_req_t                  mreq;
	logic signed [MUL_P_W-1:0] prod;
	logic [15:0]               conv_x;
	logic [LG_W-1:0]           conv_diff;
	logic [14:0]               conv_rem;
	logic signed [MIDI_W-1:0]  conv_midi;

	vpcc_mul u_mul (
		.clk  (clk),
		.req  (mreq),
		.prod (prod)
	);

	assign conv_x = (state_q == ST_TGT_LG || state_q == ST_TGT_FIN) ? tgt_q : mic_q;

	vpcc_midi_conv u_conv (
		.x      (conv_x),
		.interp (prod[LG_W+14:15]),
		.diff   (conv_diff),
		.rem    (conv_rem),
		.midi   (conv_midi)
	);

	// round a Q16 MIDI value to a note, half away from zero
	function automatic logic signed [8:0] round_note(input logic signed [MIDI_W-1:0] v);
		logic [MIDI_W-1:0] a;
		a = v[MIDI_W-1] ? MIDI_W'(-v) : MIDI_W'(v);
		a = (a + MIDI_W'(32768)) >> 16;
		return v[MIDI_W-1] ? -signed'(9'(a)) : signed'(9'(a));
	endfunction

	function automatic logic signed [14:0] clamp_semi(input logic signed [19:0] v);
		if (v > 20'sd12288) return 15'sd12288;
		else if (v < -20'sd12288) return -15'sd12288;
		else return 15'(v);
	endfunction

	// error wrap and tier weight
	logic signed [25:0] raw;
	logic [25:0]        raw_a;
	logic [10:0]        oct_t;
	logic [7:0]         k;
	logic [25:0]        kprod;
	logic signed [25:0] err_full;
	logic [18:0]        aerr;
	logic [15:0]        w_c;
	logic [10:0]        str_c;
	logic signed [15:0] shift_c;
	logic [6:0]         note_c;
	logic [MIDI_W-1:0]  note_r;

	always_comb begin
		raw   = signed'(26'(tnote_q) <<< 16) - 26'(user_q);
		raw_a = raw[25] ? 26'(-raw) : 26'(raw);
		// k = floor((|raw| + 6 oct/2) / 12 semitones); /12 by reciprocal
		oct_t = 11'((27'(raw_a) + 27'(HALF_OCT_Q16)) >> 16);
		k     = 8'((28'(oct_t) * 28'd43691) >> 19);
		kprod = 26'(k) * 26'(OCTAVE_Q16);
		err_full = raw[25] ? (raw + signed'(kprod)) : (raw - signed'(kprod));
		aerr  = err_full[25] ? 19'(-err_full) : 19'(err_full);
		// outside half a semitone or inside the pitch lock: strong weight
		w_c   = (aerr > 19'd32768 || aerr <= 19'd19660) ? 16'd42598 : 16'd29491;
		str_c = (strength_q > 11'd1024) ? 11'd1024 : strength_q;
		shift_c = (shift_q > 15'sd12288) ? 16'sd12288 :
			(shift_q < -15'sd12288) ? -16'sd12288 : 16'(shift_q);
		note_r = (conv_midi + MIDI_W'(32768)) >> 16;
		if (conv_midi[MIDI_W-1]) note_c = 7'd0;
		else if (note_r > MIDI_W'(127)) note_c = 7'd127;
		else note_c = 7'(note_r);
	end

	// multiplier operand select
	always_comb begin
		mreq.a = '0;
		mreq.b = '0;
		case (state_q)
			ST_MIC_LG, ST_TGT_LG: begin
				mreq.a = MUL_A_W'(conv_diff);
				mreq.b = MUL_B_W'(conv_rem);
			end
			ST_WS: begin
				mreq.a = MUL_A_W'(w_q);
				mreq.b = MUL_B_W'(str_c);
			end
			ST_EWS: begin
				mreq.a = MUL_A_W'(prod[26:0]);
				mreq.b = MUL_B_W'(err_q);
			end
			ST_CORR: begin
				mreq.a = MUL_A_W'(22938);
				mreq.b = MUL_B_W'(s_q);
			end
			ST_SM1: begin
				mreq.a = MUL_A_W'(42598);
				mreq.b = MUL_B_W'(corr_q);
			end
			ST_DEC1: begin
				mreq.a = MUL_A_W'(58982);
				mreq.b = MUL_B_W'(s_q);
			end
			default: begin
				mreq.a = '0;
				mreq.b = '0;
			end
		endcase
	end

	// rounding of the products
	logic [MUL_P_W-1:0] pa;
	logic [16:0]        corr_mag;
	logic signed [19:0] corr_r;
	logic signed [32:0] sm_sum;
	logic [32:0]        sm_a;
	logic signed [19:0] sm_r;
	logic [MUL_P_W-1:0] dec_mag;
	logic signed [19:0] dec_r;

	always_comb begin
		pa       = prod[MUL_P_W-1] ? MUL_P_W'(-prod) : MUL_P_W'(prod);
		corr_mag = 17'((pa + (MUL_P_W'(1) << 31)) >> 32);
		corr_r   = prod[MUL_P_W-1] ? -signed'(20'(corr_mag)) : signed'(20'(corr_mag));
		sm_sum   = 33'(acc_q) + 33'(signed'(prod[31:0]));
		sm_a     = sm_sum[32] ? 33'(-sm_sum) : 33'(sm_sum);
		sm_a     = (sm_a + 33'd32768) >> 16;
		sm_r     = sm_sum[32] ? -signed'(20'(sm_a)) : signed'(20'(sm_a));
		dec_mag  = pa >> 16;
		dec_r    = prod[MUL_P_W-1] ? -signed'(20'(dec_mag)) : signed'(20'(dec_mag));
	end

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strength_q <= 11'd1024;
			shift_q    <= '0;
			melody_q   <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_STRENGTH: strength_q <= cfg_data[10:0];
				REG_SHIFT:    shift_q    <= signed'(cfg_data);
				REG_MELODY:   melody_q   <= cfg_data[0];
				default:      ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			s_q        <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			// drain; ST_DONE loads a new result in the same cycle
			if (m_tvalid_q && m_tready && state_q != ST_DONE) m_tvalid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						mic_q       <= in_mic;
						tgt_q       <= in_tgt;
						cons_q      <= in_cons;
						run_q       <= (in_mic > 16'd960) && (in_conf >= 11'd410) && !in_cons;
						use_tgt_q   <= melody_q && (in_tgt > 16'd960);
						voiced_q    <= (in_conf >= 11'd461) && (in_mic != 16'd0);
						corrected_q <= 1'b0;
						state_q     <= ST_MIC_LG;
					end
				end
				ST_MIC_LG: state_q <= ST_MIC_FIN;
				ST_MIC_FIN: begin
					user_q  <= conv_midi;
					tnote_q <= round_note(conv_midi);
					note_q  <= voiced_q ? note_c : 7'd0;
					if (!run_q) state_q <= ST_DEC1;
					else if (use_tgt_q) state_q <= ST_TGT_LG;
					else state_q <= ST_ERR;
				end
				ST_TGT_LG: state_q <= ST_TGT_FIN;
				ST_TGT_FIN: begin
					tnote_q <= round_note(conv_midi);
					state_q <= ST_ERR;
				end
				ST_ERR: begin
					err_q   <= 20'(err_full);
					w_q     <= w_c;
					state_q <= ST_WS;
				end
				ST_WS:  state_q <= ST_EWS;
				ST_EWS: state_q <= ST_CORR;
				ST_CORR: begin
					corr_q  <= clamp_semi(corr_r);
					state_q <= ST_SM1;
				end
				ST_SM1: begin
					acc_q   <= prod[31:0];
					state_q <= ST_SM2;
				end
				ST_SM2: begin
					s_q         <= clamp_semi(sm_r);
					corrected_q <= 1'b1;
					state_q     <= ST_DONE;
				end
				ST_DEC1: state_q <= ST_DEC2;
				ST_DEC2: begin
					s_q     <= clamp_semi(dec_r);
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					// output register free or being drained this cycle
					if (!m_tvalid_q || m_tready) begin
						m_tdata_q  <= {7'd0, note_q, voiced_q, cons_q, corrected_q,
							16'(s_q) + shift_c, s_q};
						m_tvalid_q <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// the smoothed state never leaves the +-12 semitone range
	a_state_range: assert property (@(posedge clk) disable iff (!arst_n)
		(s_q <= 15'sd12288) && (s_q >= -15'sd12288))
		else $error("smoothed correction out of range");

	// an accepted item makes the block busy on the next cycle
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("block still ready after accepting an item");

	// a consonant frame never takes the correction branch
	a_cons_nocorr: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[B_CORR] && m_tdata[B_CONS]))
		else $error("correction ran on a consonant frame");

	// a note is only reported for a voiced frame
	a_note_voiced: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[40:34] != 7'd0) |-> m_tdata[B_VOICE])
		else $error("note reported for an unvoiced frame");

endmodule

FILE: src/vpcc_mul.sv
// Shared signed multiplier with registered product.
// Depends on vpcc_pkg for operand widths and the request struct.
module vpcc_mul import vpcc_pkg::*; (
	input  logic                      clk,
	input  mul_req_t                  req,
	output logic signed [MUL_P_W-1:0] prod
);

	logic signed [MUL_P_W-1:0] prod_q;

	always_ff @(posedge clk) begin
		prod_q <= MUL_P_W'(req.a) * MUL_P_W'(req.b);
	end

	assign prod = prod_q;

endmodule

FILE: src/vpcc_midi_conv.sv
// Hz (Q12.4) to MIDI (Q16) conversion: leading-one search, log2 table lookup,
// and the finish step once the interpolation product is back. Uses vpcc_pkg.
module vpcc_midi_conv import vpcc_pkg::*; (
	input  logic [15:0]              x,
	input  logic [LG_W-1:0]          interp,  // (hi-lo)*rem >> 15 from the multiplier
	output logic [LG_W-1:0]          diff,    // hi - lo
	output logic [14:0]              rem,
	output logic signed [MIDI_W-1:0] midi
);

	logic [15:0]        xx;
	logic [3:0]         e;
	logic [15:0]        mant;
	logic [14:0]        frac;
	logic [LG_BITS-1:0] idx;
	logic [LG_BITS:0]   idx_hi;
	logic [LG_W-1:0]    lo;
	logic [LG_W-1:0]    hi;
	logic [20:0]        l2;
	logic signed [26:0] dl;
	logic signed [26:0] midi_full;

	always_comb begin
		xx = (x == 16'd0) ? 16'd1 : x;
		e = 4'd0;
		for (int i = 0; i < 16; i++) begin
			if (xx[i]) e = 4'(i);
		end
		mant   = xx << (4'd15 - e);
		frac   = mant[14:0];
		idx    = frac[14 -: LG_BITS];
		idx_hi = (LG_BITS+1)'(idx) + 1'b1;
		rem    = 15'(frac << LG_BITS);
		lo     = LG_TABLE[idx];
		hi     = LG_TABLE[idx_hi];
		diff   = hi - lo;
		l2        = {1'b0, e, 16'd0} + 21'(lo) + 21'(interp);
		dl        = signed'(27'(l2)) - 27'sd837639;
		midi_full = 27'(MIDI_A4_Q16) + dl * 27'sd12;
		midi      = MIDI_W'(midi_full);
	end

endmodule

FILE: test/tb_vocal_pitch_correction_control.sv
// Self-checking testbench for vocal_pitch_correction_control: random and directed frames,
// a bit-exact predictor of the correction in a small scoreboard class, and random stalls.
// Depends on vpcc_pkg (sizes and Q16 constants) and the RTL top level.
`timescale 1ns / 1ps

module tb_vocal_pitch_correction_control import vpcc_pkg::*;;

	localparam int LIMIT_CYCLES = 200000;
	localparam int RANDOM_PHASES = 6;
	localparam int FRAMES_PER_PHASE = 184;

	typedef enum logic [1:0] {REG_STRENGTH, REG_SHIFT, REG_MELODY, REG_SPARE} reg_index_e;

	typedef struct packed {
		logic [15:0] mic_pitch;
		logic [10:0] mic_confidence;
		logic [15:0] target_pitch;
		logic        audio_present;
		logic [9:0]  zero_crossings;
		logic [10:0] frame_samples;
	} frame_t;

	typedef struct packed {
		logic signed [14:0] correction_semitones;
		logic signed [15:0] applied_semitones;
		logic               corrected;
		logic               consonant;
		logic               mic_voiced;
		logic [6:0]         mic_midi_note;
	} pitch_result_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [14:0] cfg_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [63:0] s_tdata;
	logic        s_tuser;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;

	bit stalls_on = 1'b1;
	int out_hold = 0;
	int unsigned cycles = 0;

	// Predicts one result per frame and holds the results still owed by the block.
	class pitch_scoreboard;
		longint lg_frac[LOG2_TABLE_ENTRIES+1];
		longint strength;
		longint shift_q10;
		bit     melody_on;
		longint smooth_q10;
		pitch_result_t owed[$];
		int errors;

		function new();
			logic [63:0] m;
			longint f;
			// log2(1 + i/N) as Q16, by repeated squaring of a Q30 mantissa
			for (int i = 0; i < LOG2_TABLE_ENTRIES; i++) begin
				m = (64'd1 << 30) + ((64'(i) << 30) / LOG2_TABLE_ENTRIES);
				f = 0;
				for (int b = 15; b >= 0; b--) begin
					m = (m * m) >> 30;
					if (m >= (64'd1 << 31)) begin
						f = f | (longint'(1) << b);
						m = m >> 1;
					end
				end
				lg_frac[i] = f;
			end
			lg_frac[LOG2_TABLE_ENTRIES] = Q16_ONE;
			strength = 1024;
			shift_q10 = 0;
			melody_on = 1'b0;
			smooth_q10 = 0;
			errors = 0;
		endfunction

		static function longint rnd_away(longint v, int sh);
			longint a;
			a = (v < 0) ? -v : v;
			a = (a + (longint'(1) << (sh - 1))) >>> sh;
			return (v < 0) ? -a : a;
		endfunction

		static function longint clamp(longint v, longint lo, longint hi);
			return (v < lo) ? lo : ((v > hi) ? hi : v);
		endfunction

		function void write_reg(reg_index_e idx, logic [14:0] data);
			case (idx)
				REG_STRENGTH: strength = data[10:0];
				REG_SHIFT:    shift_q10 = longint'($signed(data));
				REG_MELODY:   melody_on = data[0];
				default:      ;
			endcase
		endfunction

		// MIDI note number in Q16 of a Q12.4 frequency
		function longint note_q16(logic [15:0] hz);
			logic [15:0] x;
			logic [15:0] mant;
			int e;
			longint prod, idx, rem, lo, hi, l2;
			x = (hz == 0) ? 16'd1 : hz;
			e = 15;
			while (e > 0 && !x[e])
				e--;
			mant = x << (15 - e);
			prod = longint'(mant[14:0]) * LOG2_TABLE_ENTRIES;
			idx = prod >>> 15;
			rem = prod & 'h7FFF;
			if (idx >= LOG2_TABLE_ENTRIES) begin
				idx = LOG2_TABLE_ENTRIES - 1;
				rem = 'h7FFF;
			end
			lo = lg_frac[idx];
			hi = lg_frac[idx+1];
			l2 = longint'(e) * Q16_ONE + lo + (((hi - lo) * rem) >>> 15);
			return longint'(MIDI_A4_Q16) + 12 * (l2 - LOG2_440P4_Q16);
		endfunction

		function void note_frame(frame_t f);
			longint gain, trim, frame_len, user, goal, raw, mag, k, err, w, corr, s, m;
			pitch_result_t r;
			gain = (strength > 1024) ? 1024 : strength;
			trim = clamp(shift_q10, -12288, 12288);
			frame_len = (f.frame_samples > MAX_FRAME_SAMPLES) ? MAX_FRAME_SAMPLES
				: f.frame_samples;
			r = '0;
			// empty and single-sample frames are never consonant
			r.consonant = f.audio_present && frame_len > 1
				&& (20 * longint'(f.zero_crossings) > 7 * frame_len);
			s = smooth_q10;
			if (f.mic_pitch > 960 && f.mic_confidence >= 410 && !r.consonant) begin
				user = note_q16(f.mic_pitch);
				if (melody_on && f.target_pitch > 960)
					goal = rnd_away(note_q16(f.target_pitch), 16) * Q16_ONE;
				else
					goal = rnd_away(user, 16) * Q16_ONE;
				raw = goal - user;
				// fold into half an octave; exactly half wraps away from zero
				mag = (raw < 0) ? -raw : raw;
				k = (mag + HALF_OCT_Q16) / OCTAVE_Q16;
				if (raw < 0)
					k = -k;
				err = raw - k * OCTAVE_Q16;
				mag = (err < 0) ? -err : err;
				w = (mag > 32768 || mag <= 19660) ? 42598 : 29491;
				corr = clamp(rnd_away(err * w * gain, 32), -12288, 12288);
				s = rnd_away(s * 22938 + corr * 42598, 16);
				r.corrected = 1'b1;
			end else begin
				mag = (s < 0) ? -s : s;
				mag = (mag * 58982) >>> 16;
				s = (s < 0) ? -mag : mag;
			end
			s = clamp(s, -12288, 12288);
			smooth_q10 = s;
			r.correction_semitones = 15'(s);
			r.applied_semitones = 16'(s + trim);
			r.mic_voiced = f.mic_confidence >= 461 && f.mic_pitch > 0;
			if (r.mic_voiced) begin
				m = note_q16(f.mic_pitch);
				r.mic_midi_note = (m < 0) ? 7'd0 : 7'(clamp(rnd_away(m, 16), 0, 127));
			end
			owed = {owed, r};
		endfunction

		function void check_result(logic [47:0] d);
			pitch_result_t want;
			if (owed.size() == 0) begin
				$error("result item with none owed: %h", d);
				errors++;
				return;
			end
			want = owed.pop_front();
			if (d[14:0] !== want.correction_semitones) begin
				$error("correction_semitones: expected %0d, got %0d",
					want.correction_semitones, $signed(d[14:0]));
				errors++;
			end
			if (d[30:15] !== want.applied_semitones) begin
				$error("applied_semitones: expected %0d, got %0d",
					want.applied_semitones, $signed(d[30:15]));
				errors++;
			end
			if (d[31] !== want.corrected) begin
				$error("corrected: expected %0d, got %0d", want.corrected, d[31]);
				errors++;
			end
			if (d[32] !== want.consonant) begin
				$error("consonant: expected %0d, got %0d", want.consonant, d[32]);
				errors++;
			end
			if (d[33] !== want.mic_voiced) begin
				$error("mic_voiced: expected %0d, got %0d", want.mic_voiced, d[33]);
				errors++;
			end
			if (d[40:34] !== want.mic_midi_note) begin
				$error("mic_midi_note: expected %0d, got %0d", want.mic_midi_note, d[40:34]);
				errors++;
			end
		endfunction
	endclass

	pitch_scoreboard sb = new();

	vocal_pitch_correction_control u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Result side: check every accepted item, then hold ready low for a random stall before the next.
	always @(posedge clk) begin
		if (m_tvalid === 1'b1 && m_tready) begin
			sb.check_result(m_tdata);
			out_hold = stalls_on ? $urandom_range(0, 4) : 0;
		end else if (out_hold > 0) begin
			out_hold--;
		end
		m_tready <= (out_hold == 0);
	end

	// Watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT_CYCLES) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	function automatic frame_t mk(logic [15:0] mic, logic [10:0] conf, logic [15:0] tgt,
			logic audio, logic [9:0] zc, logic [10:0] fs);
		frame_t f;
		f.mic_pitch = mic;
		f.mic_confidence = conf;
		f.target_pitch = tgt;
		f.audio_present = audio;
		f.zero_crossings = zc;
		f.frame_samples = fs;
		return f;
	endfunction

	// Mostly sung frames that reach the correction path, some near the
	// thresholds, the rest raw noise.
	function automatic frame_t random_frame();
		frame_t f;
		int pick;
		int len;
		pick = $urandom_range(0, 99);
		f = mk(16'($urandom), 11'($urandom_range(0, 1024)), 16'($urandom), 1'($urandom),
			10'($urandom), 11'($urandom_range(1, 1024)));
		if (pick < 72) begin
			len = $urandom_range(64, 1024);
			f.mic_pitch = 16'($urandom_range(1280, 16000));
			f.mic_confidence = 11'($urandom_range(410, 1024));
			f.target_pitch = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 960))
				: 16'($urandom_range(1000, 20000));
			f.frame_samples = 11'(len);
			f.zero_crossings = 10'($urandom_range(0, len * 7 / 20));
		end else if (pick < 84) begin
			f.mic_pitch = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 2))
				: 16'($urandom_range(955, 966));
			f.mic_confidence = 11'($urandom_range(405, 466));
			f.target_pitch = 16'($urandom_range(955, 966));
		end
		if ($urandom_range(0, 39) == 0)
			f.frame_samples = ($urandom_range(0, 1) != 0) ? 11'($urandom_range(1025, 2047))
				: 11'd0;
		return f;
	endfunction

	// Send one frame after a random gap; valid stays up across back-to-back items.
	task automatic push_frame(frame_t f);
		int gap;
		gap = stalls_on ? $urandom_range(0, 4) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tdata <= {f.frame_samples, f.zero_crossings, f.target_pitch, f.mic_confidence,
			f.mic_pitch};
		s_tuser <= f.audio_present;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		sb.note_frame(f);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.owed.size() != 0)
			@(posedge clk);
	endtask

	// Only called with the block idle; writes run back to back with cfg_we held.
	task automatic program_regs(logic [14:0] str, logic [14:0] shift, logic [14:0] mel,
			bit poke_spare);
		reg_index_e order[4] = '{REG_STRENGTH, REG_SHIFT, REG_MELODY, REG_SPARE};
		logic [14:0] vals[4];
		int n;
		vals = '{str, shift, mel, 15'($urandom)};
		n = poke_spare ? 4 : 3;
		for (int i = 0; i < n; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= order[i];
			cfg_data <= vals[i];
			@(posedge clk);
			sb.write_reg(order[i], vals[i]);
		end
		cfg_we <= 1'b0;
	endtask

	initial begin
		logic [14:0] str_set[RANDOM_PHASES];
		logic [14:0] shift_set[RANDOM_PHASES];
		logic [14:0] mel_set[RANDOM_PHASES];
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_STRENGTH;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: full strength, no shift, melody off
		push_frame(mk(16'd0, 11'd0, 16'd0, 1'b0, 10'd0, 11'd1));
		push_frame(mk(16'hFFFF, 11'd1024, 16'hFFFF, 1'b1, 10'd0, 11'd1024));
		push_frame(mk(16'd961, 11'd410, 16'd0, 1'b0, 10'd0, 11'd1024));
		push_frame(mk(16'd960, 11'd1024, 16'd0, 1'b0, 10'd0, 11'd512));
		push_frame(mk(16'd7040, 11'd461, 16'd0, 1'b0, 10'd5, 11'd256));
		// lowest pitch: note below zero clamps
		push_frame(mk(16'd1, 11'd461, 16'd0, 1'b0, 10'd0, 11'd256));
		push_frame(mk(16'd0, 11'd1024, 16'd0, 1'b0, 10'd0, 11'd256));
		push_frame(mk(16'd5000, 11'd409, 16'd0, 1'b0, 10'd0, 11'd256));
		push_frame(mk(16'd5000, 11'd460, 16'd0, 1'b0, 10'd0, 11'd256));
		// consonant boundary at 0.35 of the frame
		push_frame(mk(16'd5000, 11'd1024, 16'd0, 1'b1, 10'd359, 11'd1024));
		push_frame(mk(16'd5000, 11'd1024, 16'd0, 1'b1, 10'd358, 11'd1024));
		push_frame(mk(16'd5000, 11'd1024, 16'd0, 1'b0, 10'h3FF, 11'd100));
		// empty and single-sample frames
		push_frame(mk(16'd5000, 11'd1024, 16'd0, 1'b1, 10'h3FF, 11'd0));
		push_frame(mk(16'd5000, 11'd1024, 16'd0, 1'b1, 10'd1, 11'd1));
		// overlong frame saturates to the max length
		push_frame(mk(16'd5000, 11'd1024, 16'd0, 1'b1, 10'd400, 11'h7FF));
		push_frame(mk(16'd5000, 11'd1024, 16'd0, 1'b1, 10'd358, 11'd1500));
		drain();

		// saturating strength and shift, melody on
		program_regs(15'd2047, 15'h3FFF, 15'd1, 1'b1);
		push_frame(mk(16'd3520, 11'd1024, 16'd10000, 1'b0, 10'd0, 11'd512));
		push_frame(mk(16'd3520, 11'd1024, 16'd960, 1'b0, 10'd0, 11'd512));
		push_frame(mk(16'd3520, 11'd1024, 16'd961, 1'b0, 10'd0, 11'd512));
		push_frame(mk(16'd961, 11'd1024, 16'hFFFF, 1'b0, 10'd0, 11'd512));
		push_frame(mk(16'hFFFF, 11'd1024, 16'd961, 1'b0, 10'd0, 11'd512));
		push_frame(mk(16'd4000, 11'd1024, 16'd0, 1'b0, 10'd0, 11'd512));
		push_frame(mk(16'd0, 11'd0, 16'd5000, 1'b0, 10'd0, 11'd512));
		push_frame(mk(16'd0, 11'd0, 16'd5000, 1'b0, 10'd0, 11'd512));
		drain();

		// random phases; register settings include the extremes and junk upper bits
		str_set = '{15'd0, 15'h7FFF, 15'd1024, 15'd1, 15'($urandom_range(0, 1024)), 15'd1025};
		shift_set = '{15'h4000, 15'h3FFF, 15'd12288, 15'h5000, 15'd0, 15'($urandom)};
		mel_set = '{15'd1, 15'h7FFE, 15'd1, 15'd1, 15'd0, 15'($urandom)};
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			stalls_on = (p != 2);
			program_regs(str_set[p], shift_set[p], mel_set[p], p == 1 || p == 4);
			for (int i = 0; i < FRAMES_PER_PHASE; i++)
				push_frame(random_frame());
			drain();
		end

		repeat (16) @(posedge clk);
		if (sb.errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

FILE: files.f
src/vpcc_pkg.sv
src/vpcc_mul.sv
src/vpcc_midi_conv.sv
src/vocal_pitch_correction_control.sv
test/tb_vocal_pitch_correction_control.sv
